// File: design/cisr_pkg.sv
// shared types, constants and helpers for the case-insensitive stream replacer
// no dependencies; imported by every module of the block
package cisr_pkg;

  localparam int MAX_LEN = 8;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 4;
  localparam int IDX_W   = 3;
  localparam int WORD_W  = MAX_LEN * BYTE_W;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_PATTERN_LENGTH     = 2'd0,
    REG_PATTERN_BYTES      = 2'd1,
    REG_REPLACEMENT_LENGTH = 2'd2,
    REG_REPLACEMENT_BYTES  = 2'd3
  } reg_index_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SHED,
    ST_REPL,
    ST_BARE
  } state_t;

  // one result request from the sequencer to the output stage
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              has_byte;
    logic              last;
  } emit_req_t;

  // ascii upper case to lower case, other bytes unchanged
  function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  // clamp a length register into minimum..MAX_LEN
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                 input logic [LEN_W-1:0] minimum);
    logic [LEN_W-1:0] n;
    n = v;
    if (n < minimum) begin
      n = minimum;
    end
    if (n > LEN_W'(MAX_LEN)) begin
      n = LEN_W'(MAX_LEN);
    end
    return n;
  endfunction

endpackage

// File: design/cisr_prefix.sv
// prefix compare unit: checks the first count held bytes against the pattern
// ignoring ascii letter case; depends on cisr_pkg
module cisr_prefix import cisr_pkg::*; (
  input  logic [WORD_W-1:0] held_vec,
  input  logic [WORD_W-1:0] pattern,
  input  logic [LEN_W-1:0]  count,
  output logic              ok
);

  logic [MAX_LEN-1:0] hit;

  // per-byte folded compare, bytes at or above count always pass
  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      hit[i] = (LEN_W'(i) >= count) ||
               (fold(held_vec[i*BYTE_W +: BYTE_W]) == fold(pattern[i*BYTE_W +: BYTE_W]));
    end
  end

  assign ok = &hit;

endmodule

// File: design/cisr_seq.sv
// sequencer and held-byte buffer: appends, matches, replaces and sheds bytes
// depends on cisr_pkg and cisr_prefix
module cisr_seq import cisr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_last,
  input  logic [LEN_W-1:0]  plen,
  input  logic [WORD_W-1:0] pattern,
  input  logic [LEN_W-1:0]  rlen,
  input  logic [WORD_W-1:0] replacement,
  output emit_req_t         req,
  input  logic              req_ready
);

  state_t              state, state_next;
  logic [LEN_W-1:0]    cnt;
  logic                last_flag;
  logic                emitted;
  logic [IDX_W-1:0]    rep_idx;
  logic [BYTE_W-1:0]   held [MAX_LEN];
  logic [WORD_W-1:0]   held_vec;
  logic                ok;
  logic [IDX_W-1:0]    wr_idx;
  logic                full_match;
  logic                shed_go;
  logic                rep_end;
  logic                fire;

  // held buffer viewed as one word for the compare unit
  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      held_vec[i*BYTE_W +: BYTE_W] = held[i];
    end
  end

  cisr_prefix u_prefix (
    .held_vec (held_vec),
    .pattern  (pattern),
    .count    (cnt),
    .ok       (ok)
  );

  // append slot, the last entry is reused when the buffer is full
  assign wr_idx     = (cnt >= LEN_W'(MAX_LEN)) ? IDX_W'(MAX_LEN - 1) : cnt[IDX_W-1:0];
  assign full_match = (cnt == plen) && ok;
  assign shed_go    = (cnt != '0) && (last_flag || !((cnt < plen) && ok));
  assign rep_end    = ({1'b0, rep_idx} == (rlen - LEN_W'(1)));
  assign fire       = req.valid && req_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and result requests
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    req        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (full_match) begin
          if (rlen != '0) begin
            state_next = ST_REPL;
          end else if (last_flag) begin
            state_next = ST_BARE;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_SHED;
        end
      end
      ST_SHED: begin
        if (shed_go) begin
          req.valid    = 1'b1;
          req.data     = held[0];
          req.has_byte = 1'b1;
          req.last     = last_flag && (cnt == LEN_W'(1));
        end else if (last_flag && !emitted) begin
          state_next = ST_BARE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_REPL: begin
        req.valid    = 1'b1;
        req.data     = replacement[rep_idx*BYTE_W +: BYTE_W];
        req.has_byte = 1'b1;
        req.last     = last_flag && rep_end;
        if (req_ready && rep_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_BARE: begin
        req.valid    = 1'b1;
        req.data     = '0;
        req.has_byte = 1'b0;
        req.last     = 1'b1;
        if (req_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // held count and step flags
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      last_flag <= 1'b0;
      emitted   <= 1'b0;
      rep_idx   <= '0;
    end else begin
      if (state == ST_IDLE && in_valid) begin
        cnt       <= LEN_W'(wr_idx) + LEN_W'(1);
        last_flag <= in_last;
        emitted   <= 1'b0;
      end
      if (state == ST_DECIDE && full_match) begin
        cnt     <= '0;
        rep_idx <= '0;
      end
      if (state == ST_SHED && fire) begin
        cnt     <= cnt - LEN_W'(1);
        emitted <= 1'b1;
      end
      if (state == ST_REPL && fire) begin
        rep_idx <= rep_idx + IDX_W'(1);
        emitted <= 1'b1;
      end
    end
  end

  // held bytes: append at the tail, shift out at the head
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      held[wr_idx] <= in_byte;
    end else if (state == ST_SHED && fire) begin
      for (int i = 0; i < MAX_LEN - 1; i++) begin
        held[i] <= held[i+1];
      end
    end
  end

endmodule

// File: design/cisr_ostage.sv
// output register stage: holds one result until the sink takes it
// depends on cisr_pkg
module cisr_ostage import cisr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  emit_req_t         req,
  output logic              req_ready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [BYTE_W-1:0] m_tdata,
  output logic              m_tuser,
  output logic              m_tlast
);

  assign req_ready = !m_tvalid || m_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (req_ready) begin
      m_tvalid <= req.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (req_ready && req.valid) begin
      m_tdata <= req.data;
      m_tuser <= req.has_byte;
      m_tlast <= req.last;
    end
  end

endmodule

// File: design/case_insensitive_stream_replace_top.sv
// Case-insensitive find and replace over a byte stream. Every leftmost,
// non-overlapping occurrence of the pattern (ascii letters match either
// case) is replaced by the replacement; bytes of a partial match are held
// and flushed at tlast, where the final result carries tlast (a bare result
// with tuser 0 when nothing else is due). One byte at a time is processed:
// no new input byte is taken until the sequencer is back in idle. After a
// full match it emits the replacement bytes, otherwise it sheds held bytes
// and may end with a bare end marker; one held byte is shed or one
// replacement byte emitted per cycle while the sink does not stall.
// The user must write configuration only while idle; it is not enforced.
// depends on cisr_pkg, cisr_seq, cisr_prefix, cisr_ostage
module case_insensitive_stream_replace_top import cisr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [WORD_W-1:0] cfg_data,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // in_byte
  input  logic              s_tlast,   // in_last
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // out_byte
  output logic              m_tuser,   // has_byte
  output logic              m_tlast    // out_last
);

  logic [LEN_W-1:0]  pattern_length;
  logic [WORD_W-1:0] pattern_bytes;
  logic [LEN_W-1:0]  replacement_length;
  logic [WORD_W-1:0] replacement_bytes;
  logic [LEN_W-1:0]  plen;
  logic [LEN_W-1:0]  rlen;
  emit_req_t         req;
  logic              req_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length     <= LEN_W'(1);
      pattern_bytes      <= '0;
      replacement_length <= '0;
      replacement_bytes  <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_PATTERN_LENGTH:     pattern_length     <= cfg_data[LEN_W-1:0];
        REG_PATTERN_BYTES:      pattern_bytes      <= cfg_data;
        REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // lengths in their working ranges
  assign plen = clamp_len(pattern_length, LEN_W'(1));
  assign rlen = clamp_len(replacement_length, LEN_W'(0));

  cisr_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_byte     (s_tdata),
    .in_last     (s_tlast),
    .plen        (plen),
    .pattern     (pattern_bytes),
    .rlen        (rlen),
    .replacement (replacement_bytes),
    .req         (req),
    .req_ready   (req_ready)
  );

  cisr_ostage u_ostage (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_ready (req_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
